FILE: rtl/dtoi_pkg.sv
`timescale 1ns / 1ps

package dtoi_pkg;

    localparam int DTOI_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [1:0] CFG_WIDTH_SELECT = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE  = 2'd1;

    localparam logic [1:0] WS_8  = 2'd0;
    localparam logic [1:0] WS_16 = 2'd1;
    localparam logic [1:0] WS_32 = 2'd2;
    localparam logic [1:0] WS_64 = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [63:0] LIM_U8   = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] LIM_U16  = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] LIM_U32  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LIM_U64  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_SP8  = 64'h0000_0000_0000_007F;
    localparam logic [63:0] LIM_SP16 = 64'h0000_0000_0000_7FFF;
    localparam logic [63:0] LIM_SP32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_SP64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_SN8  = 64'h0000_0000_0000_0080;
    localparam logic [63:0] LIM_SN16 = 64'h0000_0000_0000_8000;
    localparam logic [63:0] LIM_SN32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIM_SN64 = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] width_select;
        logic       signed_mode;
    } t_cfg;

    typedef struct packed {
        logic       is_num;
        logic       is_minus;
        logic       is_plus;
        logic [3:0] digit;
        logic       last;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [63:0] lim_full(logic [1:0] ws, logic sm, logic neg);
        logic [63:0] lim;
        lim = LIM_U64;
        if (!sm) begin
            unique case (ws)
                WS_8:    lim = LIM_U8;
                WS_16:   lim = LIM_U16;
                WS_32:   lim = LIM_U32;
                default: lim = LIM_U64;
            endcase
        end else if (neg) begin
            unique case (ws)
                WS_8:    lim = LIM_SN8;
                WS_16:   lim = LIM_SN16;
                WS_32:   lim = LIM_SN32;
                default: lim = LIM_SN64;
            endcase
        end else begin
            unique case (ws)
                WS_8:    lim = LIM_SP8;
                WS_16:   lim = LIM_SP16;
                WS_32:   lim = LIM_SP32;
                default: lim = LIM_SP64;
            endcase
        end
        return lim;
    endfunction

    function automatic logic [63:0] lim_quot(logic [1:0] ws, logic sm, logic neg);
        logic [63:0] q;
        q = LIM_U64 / 10;
        if (!sm) begin
            unique case (ws)
                WS_8:    q = LIM_U8 / 10;
                WS_16:   q = LIM_U16 / 10;
                WS_32:   q = LIM_U32 / 10;
                default: q = LIM_U64 / 10;
            endcase
        end else if (neg) begin
            unique case (ws)
                WS_8:    q = LIM_SN8 / 10;
                WS_16:   q = LIM_SN16 / 10;
                WS_32:   q = LIM_SN32 / 10;
                default: q = LIM_SN64 / 10;
            endcase
        end else begin
            unique case (ws)
                WS_8:    q = LIM_SP8 / 10;
                WS_16:   q = LIM_SP16 / 10;
                WS_32:   q = LIM_SP32 / 10;
                default: q = LIM_SP64 / 10;
            endcase
        end
        return q;
    endfunction

    function automatic logic [3:0] lim_rem(logic [1:0] ws, logic sm, logic neg);
        logic [3:0] r;
        r = 4'(LIM_U64 % 10);
        if (!sm) begin
            unique case (ws)
                WS_8:    r = 4'(LIM_U8 % 10);
                WS_16:   r = 4'(LIM_U16 % 10);
                WS_32:   r = 4'(LIM_U32 % 10);
                default: r = 4'(LIM_U64 % 10);
            endcase
        end else if (neg) begin
            unique case (ws)
                WS_8:    r = 4'(LIM_SN8 % 10);
                WS_16:   r = 4'(LIM_SN16 % 10);
                WS_32:   r = 4'(LIM_SN32 % 10);
                default: r = 4'(LIM_SN64 % 10);
            endcase
        end else begin
            unique case (ws)
                WS_8:    r = 4'(LIM_SP8 % 10);
                WS_16:   r = 4'(LIM_SP16 % 10);
                WS_32:   r = 4'(LIM_SP32 % 10);
                default: r = 4'(LIM_SP64 % 10);
            endcase
        end
        return r;
    endfunction

endpackage

FILE: rtl/dtoi_front.sv
`timescale 1ns / 1ps

module dtoi_front
    import dtoi_pkg::*;
(
    input  t_in_item i_item,
    output t_cls     o_cls
);

    logic [7:0] offset;

    assign offset = i_item.text_byte - CH_0;

    always_comb begin
        o_cls.is_num   = (i_item.text_byte >= CH_0) && (i_item.text_byte <= CH_9);
        o_cls.is_minus = (i_item.text_byte == CH_MINUS);
        o_cls.is_plus  = (i_item.text_byte == CH_PLUS);
        o_cls.digit    = offset[3:0];
        o_cls.last     = i_item.last_byte;
    end

endmodule

FILE: rtl/dtoi_queue.sv
`timescale 1ns / 1ps

module dtoi_queue
    import dtoi_pkg::*;
#(
    parameter int DEPTH = DTOI_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls      i_data,
    input  logic      i_pop,
    output t_cls      o_data,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

FILE: rtl/dtoi_back.sv
`timescale 1ns / 1ps

module dtoi_back
    import dtoi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cls      i_item,
    input  t_q_status i_q,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    t_phase      r_phase;
    logic [63:0] r_mag;
    logic        r_neg;
    logic        r_fail;
    t_phase      n_phase;
    logic [63:0] n_mag;
    logic        n_neg;
    logic        n_fail;

    logic        r_out_valid;
    logic [63:0] r_out_mag;
    logic        r_out_neg;
    logic        r_out_bad;

    logic [63:0] quot;
    logic [3:0]  rem;
    logic        fits;
    logic        took;
    logic        bad;
    logic [63:0] mag_x10;

    assign quot    = lim_quot(i_cfg.width_select, i_cfg.signed_mode, r_neg);
    assign rem     = lim_rem(i_cfg.width_select, i_cfg.signed_mode, r_neg);
    assign fits    = !((r_mag > quot) || ((r_mag == quot) && (i_item.digit > rem)));
    assign mag_x10 = (r_mag << 3) + (r_mag << 1) + {60'd0, i_item.digit};

    assign o_pop = !i_q.empty && (!i_item.last || !r_out_valid || !i_out_stall);

    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_fail  = r_fail;
        took    = 1'b0;
        if (!r_fail) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_item.is_minus) begin
                        if (i_cfg.signed_mode) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end else if (i_item.is_plus) begin
                        n_phase = PH_SIGN;
                    end else if (i_item.is_num) begin
                        took = fits;
                        n_fail = !fits;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (i_item.is_num) begin
                        took = fits;
                        n_fail = !fits;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (i_item.is_num) begin
                        took = fits;
                        n_fail = !fits;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        if (took) begin
            n_mag   = mag_x10;
            n_phase = PH_DIGITS;
        end
    end

    // A digit taken at this byte was already checked against the current limit.
    always_comb begin
        bad = n_fail || (n_phase == PH_START) || (n_phase == PH_SIGN)
            || (n_neg && !i_cfg.signed_mode)
            || (!took && (r_mag > lim_full(i_cfg.width_select, i_cfg.signed_mode, r_neg)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.last) begin
                    r_phase <= PH_START;
                    r_mag   <= '0;
                    r_neg   <= 1'b0;
                    r_fail  <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_mag   <= n_mag;
                    r_neg   <= n_neg;
                    r_fail  <= n_fail;
                end
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_mag <= n_mag;
            r_out_neg <= n_neg;
            r_out_bad <= bad;
        end
    end

    always_comb begin
        o_out_valid = r_out_valid;
        if (r_out_bad) begin
            o_out_item.value_bits = '0;
            o_out_item.status     = STATUS_FAIL;
        end else begin
            o_out_item.value_bits = r_out_neg ? (~r_out_mag) + 64'd1 : r_out_mag;
            o_out_item.status     = STATUS_OK;
        end
    end

endmodule

FILE: rtl/decimal_text_to_integer_top.sv
`timescale 1ns / 1ps

// Converts a decimal text, one byte per item on the input channel, into an integer.
// The input channel takes a byte and a last-byte flag; o_in_stall holds it off.
// The output channel gives one item, value and status, for each text, on its last byte.
// Texts are an optional sign and then decimal digits; later non-digit bytes are ignored.
// The configuration channel is always ready: index 0 selects the width, index 1 the sign.
// Write configuration only while no text result is pending in the block; it is not enforced.
// One byte per cycle while the queue has room, set by the multiply-by-ten and range compare.
// A last byte passes through the queue and then the output register before its result can be taken.
// While the receiver stalls, the held result stays put and non-last bytes keep flowing.
// A further last byte then waits in the two-entry queue, and the input stalls once it fills.
// Reset selects 64-bit signed results, clears the text state and empties the queue.
module decimal_text_to_integer_top
    import dtoi_pkg::*;
#(
    parameter int QUEUE_DEPTH = DTOI_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_cls      front_cls;
    t_cls      q_head;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_stat.full;
    assign push        = i_in_valid && !q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_select <= WS_64;
            r_cfg.signed_mode  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH_SELECT: r_cfg.width_select <= i_cfg_data[1:0];
                CFG_SIGNED_MODE:  r_cfg.signed_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dtoi_front u_front (
        .i_item (i_in_item),
        .o_cls  (front_cls)
    );

    dtoi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_cls),
        .i_pop    (pop),
        .o_data   (q_head),
        .o_status (q_stat)
    );

    dtoi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (q_head),
        .i_q         (q_stat),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("Back end took an item from an empty queue.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == STATUS_FAIL)) |-> (o_out_item.value_bits == '0))
        else $error("Failed conversion carries a nonzero value.");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(pop && q_head.last))
        else $error("Result appeared without a last byte being processed.");
`endif

endmodule
